### hw/rtl/approximate_shift_and_matcher_unit_defines.svh
// Assertion macros for the approximate shift-and matcher.
// Used by the top level only; depends on nothing else.
`ifndef APPROXIMATE_SHIFT_AND_MATCHER_UNIT_DEFINES_SVH
`define APPROXIMATE_SHIFT_AND_MATCHER_UNIT_DEFINES_SVH

// Checks that a condition implies another one in the same cycle.
`define ASM_ASSERT_NOW(label, clk, rst_n, cond, expect_now) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
		else $error("matcher check failed");

// Checks that a condition implies a sequence starting in the next cycle.
`define ASM_ASSERT_NEXT(label, clk, rst_n, cond, expect_next) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
		else $error("matcher check failed");

`endif

### hw/rtl/asm_pkg.sv
// Shared constants and types of the approximate shift-and matcher.
// Used by the front, the back and the top level; depends on nothing.
package asm_pkg;

	localparam int PATTERN_MAX_DEF      = 32;
	localparam int ERROR_LEVELS_MAX_DEF = 3;

	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int PATTERN_REGS  = 4;
	localparam int PATTERN_BYTES = 8 * PATTERN_REGS;
	localparam int PATTERN_BITS  = 8 * PATTERN_BYTES;
	localparam int LEN_W         = 6;
	localparam int LEN_EXT_W     = 7;
	localparam int ERR_W         = 2;
	localparam int LIMIT_W       = 3;
	localparam int POS_W         = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_0  = 3'd0,
		CFG_PATTERN_1  = 3'd1,
		CFG_PATTERN_2  = 3'd2,
		CFG_PATTERN_3  = 3'd3,
		CFG_LENGTH     = 3'd4,
		CFG_MAX_ERRORS = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

### hw/rtl/approximate_shift_and_matcher_unit.sv
// Top level of the approximate shift-and matcher with configuration registers.
// Depends on asm_pkg, asm_front, asm_back and the assertion macro header.
// The block searches a byte stream for a pattern of up to PATTERN_MAX bytes
// with at most max_errors edits and gives one result per text byte. It takes
// one byte per clock cycle in steady state while the output is taken. After
// its byte is accepted, the byte's compare result is written into the
// two-entry queue and then loaded into the output register, where the result
// is presented. The error rows are updated when the byte leaves the queue.
// While the output is held, the queue takes two more bytes before the input
// stalls. Configuration is written through its own channel, which is always
// ready.
`include "approximate_shift_and_matcher_unit_defines.svh"

module approximate_shift_and_matcher_unit import asm_pkg::*; #(
	parameter int PATTERN_MAX      = PATTERN_MAX_DEF,
	parameter int ERROR_LEVELS_MAX = ERROR_LEVELS_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             text_byte,
	input  logic                   new_text,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   match_found,
	output logic [ERR_W-1:0]       match_errors,
	output logic [POS_W-1:0]       end_position,
	output logic signed [POS_W:0]  start_position
);

	logic [CFG_DATA_W-1:0]  pattern_q [PATTERN_REGS];
	logic [PATTERN_BITS-1:0] pattern;
	logic [LEN_W-1:0]       length_q;
	logic [ERR_W-1:0]       max_errors_q;
	logic                   q_valid;
	logic                   q_ready;
	logic [PATTERN_MAX-1:0] q_hit;
	logic                   q_new_text;
	q_status_t              q_status;

	assign cfg_ready = 1'b1;

	for (genvar r = 0; r < PATTERN_REGS; r++) begin : g_pat
		assign pattern[r*CFG_DATA_W +: CFG_DATA_W] = pattern_q[r];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < PATTERN_REGS; r++) begin
				pattern_q[r] <= '0;
			end
			length_q     <= LEN_W'(1);
			max_errors_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PATTERN_0:  pattern_q[0] <= cfg_data;
				CFG_PATTERN_1:  pattern_q[1] <= cfg_data;
				CFG_PATTERN_2:  pattern_q[2] <= cfg_data;
				CFG_PATTERN_3:  pattern_q[3] <= cfg_data;
				CFG_LENGTH:     length_q     <= cfg_data[LEN_W-1:0];
				CFG_MAX_ERRORS: max_errors_q <= cfg_data[ERR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	asm_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.new_text   (new_text),
		.pattern    (pattern),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_hit      (q_hit),
		.q_new_text (q_new_text),
		.q_status   (q_status)
	);

	asm_back #(
		.PATTERN_MAX      (PATTERN_MAX),
		.ERROR_LEVELS_MAX (ERROR_LEVELS_MAX)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_hit          (q_hit),
		.q_new_text     (q_new_text),
		.pattern_length (length_q),
		.max_errors     (max_errors_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_found    (match_found),
		.match_errors   (match_errors),
		.end_position   (end_position),
		.start_position (start_position)
	);

	`ASM_ASSERT_NOW(a_no_errors_without_match, clk, arst_n, out_valid && !match_found, match_errors == '0)
	`ASM_ASSERT_NEXT(a_idle_latency, clk, arst_n, in_valid && in_ready && q_status.empty && !out_valid, ##1 out_valid)
	`ASM_ASSERT_NOW(a_full_blocks_input, clk, arst_n, q_status.full, !in_ready && q_valid)

endmodule

### hw/rtl/asm_front.sv
// Front part of the matcher: accepts text bytes, compares each with all
// pattern bytes and holds the result in a two-entry queue. Uses asm_pkg.
module asm_front import asm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              text_byte,
	input  logic                    new_text,
	input  logic [PATTERN_BITS-1:0] pattern,
	output logic                    q_valid,
	input  logic                    q_ready,
	output logic [PATTERN_MAX-1:0]  q_hit,
	output logic                    q_new_text,
	output q_status_t               q_status
);

	logic [PATTERN_MAX-1:0] hit;
	logic [PATTERN_MAX-1:0] entry_hit_q [2];
	logic                   entry_nt_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   push;
	logic                   pop;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
		if (i < PATTERN_BYTES) begin : g_real
			assign hit[i] = (pattern[8*i +: 8] == text_byte);
		end else begin : g_zero
			assign hit[i] = (text_byte == 8'd0);
		end
	end

	assign in_ready       = (count_q != 2'd2);
	assign push           = in_valid && in_ready;
	assign q_valid        = (count_q != 2'd0);
	assign pop            = q_valid && q_ready;
	assign q_hit          = entry_hit_q[rd_ptr_q];
	assign q_new_text     = entry_nt_q[rd_ptr_q];
	assign q_status.empty = (count_q == 2'd0);
	assign q_status.full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_hit_q[wr_ptr_q] <= hit;
			entry_nt_q[wr_ptr_q]  <= new_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### hw/rtl/asm_back.sv
// Back part of the matcher: updates the error rows and the position for
// each queued request and holds the result in an output register. Uses asm_pkg.
module asm_back import asm_pkg::*; #(
	parameter int PATTERN_MAX      = PATTERN_MAX_DEF,
	parameter int ERROR_LEVELS_MAX = ERROR_LEVELS_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  logic [PATTERN_MAX-1:0] q_hit,
	input  logic                   q_new_text,
	input  logic [LEN_W-1:0]       pattern_length,
	input  logic [ERR_W-1:0]       max_errors,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   match_found,
	output logic [ERR_W-1:0]       match_errors,
	output logic [POS_W-1:0]       end_position,
	output logic signed [POS_W:0]  start_position
);

	localparam int NUM_ROWS = ERROR_LEVELS_MAX + 1;

	logic [PATTERN_MAX-1:0] rows_q  [NUM_ROWS];
	logic [PATTERN_MAX-1:0] rst_row [NUM_ROWS];
	logic [PATTERN_MAX-1:0] old_row [NUM_ROWS];
	logic [PATTERN_MAX-1:0] new_row [NUM_ROWS];
	logic [PATTERN_MAX-1:0] keep;
	logic [PATTERN_MAX-1:0] top;
	logic [LEN_EXT_W-1:0]   m;
	logic [LIMIT_W-1:0]     limit;
	logic                   found;
	logic [ERR_W-1:0]       best;
	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       cur_pos;
	logic                   out_valid_q;
	logic                   pop;

	always_comb begin
		if (pattern_length == '0) begin
			m = LEN_EXT_W'(1);
		end else if ({1'b0, pattern_length} > LEN_EXT_W'(PATTERN_MAX)) begin
			m = LEN_EXT_W'(PATTERN_MAX);
		end else begin
			m = {1'b0, pattern_length};
		end
		if ({1'b0, max_errors} > LIMIT_W'(ERROR_LEVELS_MAX)) begin
			limit = LIMIT_W'(ERROR_LEVELS_MAX);
		end else begin
			limit = {1'b0, max_errors};
		end
		for (int j = 0; j < PATTERN_MAX; j++) begin
			keep[j] = (LEN_EXT_W'(j) < m);
			top[j]  = (LEN_EXT_W'(j) == m - LEN_EXT_W'(1));
		end
	end

	always_comb begin
		for (int d = 0; d < NUM_ROWS; d++) begin
			for (int j = 0; j < PATTERN_MAX; j++) begin
				rst_row[d][j] = (j < d);
			end
			old_row[d] = (q_new_text ? rst_row[d] : rows_q[d]) & keep;
		end
		new_row[0] = ((old_row[0] << 1) | PATTERN_MAX'(1)) & q_hit & keep;
		for (int d = 1; d < NUM_ROWS; d++) begin
			new_row[d] = (((old_row[d] << 1) | PATTERN_MAX'(1)) & q_hit)
				| old_row[d-1]
				| ((old_row[d-1] << 1) | PATTERN_MAX'(1))
				| ((new_row[d-1] << 1) | PATTERN_MAX'(1));
			new_row[d] = new_row[d] & keep;
		end
		found = 1'b0;
		best  = '0;
		for (int d = 0; d < NUM_ROWS; d++) begin
			if (!found && (LIMIT_W'(d) <= limit) && ((new_row[d] & top) != '0)) begin
				found = 1'b1;
				best  = ERR_W'(d);
			end
		end
	end

	assign cur_pos   = q_new_text ? '0 : pos_q;
	assign q_ready   = !out_valid_q || out_ready;
	assign pop       = q_valid && q_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			match_found    <= found;
			match_errors   <= best;
			end_position   <= cur_pos;
			start_position <= $signed({1'b0, cur_pos} + (POS_W+1)'(1)
				- (POS_W+1)'(m));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_ROWS; d++) begin
				for (int j = 0; j < PATTERN_MAX; j++) begin
					rows_q[d][j] <= (j < d);
				end
			end
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				for (int d = 0; d < NUM_ROWS; d++) begin
					rows_q[d] <= new_row[d];
				end
				pos_q <= cur_pos + POS_W'(1);
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
